// ===== hw/rtl/lfg_pkg.sv =====
// Shared types and constants for the lagged Fibonacci (absolute difference) generator.
package lfg_pkg;

    localparam int MAX_LAG   = 64;
    localparam int WORD_W    = 31;
    localparam int LAG_W     = 7;
    localparam int PTR_W     = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
    localparam int CNT_W     = $clog2(MAX_LAG + 1);
    localparam int SUM_W     = ((CNT_W > LAG_W) ? CNT_W : LAG_W) + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LAG_A = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_B = CFG_IDX_W'(1);

    localparam logic [LAG_W-1:0] LAG_A_RESET = LAG_W'(24);
    localparam logic [LAG_W-1:0] LAG_B_RESET = LAG_W'(55);

    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_APPEND   = 2'd1,
        OP_GENERATE = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

endpackage

// ===== hw/rtl/lagged_fibonacci_abs_generator_top.sv =====
// Lagged Fibonacci generator, absolute-difference form, with a streaming interface.
// Latency: a generate passes through stage 1 and then the output reg before its result shows on m_tvalid.
// Throughput: one item per cycle while the result stream is not stalled; the history RAM has a registered read
//   with write bypass, so a generate may tap the word pushed by the item just ahead of it.
// Reset (aresetn low, synchronous): lags to 24/55, history empty, pipeline and output cleared.
// The history RAM itself is not cleared; the fill count keeps unwritten words from being read.
module lagged_fibonacci_abs_generator_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [30:0] seed_value, [31] zero
    input  logic [1:0]                    s_tuser,   // [1:0] operation
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // [30:0] value, [31] zero
    output logic [0:0]                    m_tuser,   // [0] status
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lfg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfg_pkg::LAG_W-1:0]     cfg_data
);
    import lfg_pkg::*;

    // wrap-around increment of the write pointer
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(MAX_LAG - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // RAM address of the word lag places behind pointer p
    function automatic logic [PTR_W-1:0] tap_addr(input logic [PTR_W-1:0] p,
                                                  input logic [LAG_W-1:0] lag);
        logic [SUM_W-1:0] pe;
        logic [SUM_W-1:0] le;
        logic [SUM_W-1:0] r;
        pe = SUM_W'(p);
        le = SUM_W'(lag);
        if (le > pe) begin
            r = pe + SUM_W'(MAX_LAG) - le;
        end else begin
            r = pe - le;
        end
        return r[PTR_W-1:0];
    endfunction

    // configuration
    logic [LAG_W-1:0]  lag_a_reg;
    logic [LAG_W-1:0]  lag_b_reg;

    // history state
    logic [WORD_W-1:0] hist_mem [MAX_LAG];
    logic [PTR_W-1:0]  wp_reg;
    logic [PTR_W-1:0]  wp_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    // stage 1: accepted item plus its two tapped words
    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [WORD_W-1:0] s1_seed_reg;
    logic [WORD_W-1:0] rd_a_reg;
    logic [WORD_W-1:0] rd_b_reg;

    // output register
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_value_reg;
    logic              out_status_reg;

    logic              s1_go;
    logic              in_xfer;
    logic [LAG_W-1:0]  need;
    logic              lag_ok;
    logic [WORD_W-1:0] diff;
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic [PTR_W-1:0]  raddr_a;
    logic [PTR_W-1:0]  raddr_b;

    assign cfg_ready = 1'b1;

    // Stage 1 retires non-generate items at once; a generate waits for room in the output reg.
    assign s1_go    = s1_valid_reg &&
                      ((s1_op_reg != OP_GENERATE) || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_go;
    assign in_xfer  = s_tvalid && s_tready;

    assign need   = (lag_a_reg > lag_b_reg) ? lag_a_reg : lag_b_reg;
    assign lag_ok = (lag_a_reg != '0) && (lag_b_reg != '0) &&
                    (SUM_W'(count_reg) >= SUM_W'(need));
    assign diff   = (rd_a_reg > rd_b_reg) ? (rd_a_reg - rd_b_reg) : (rd_b_reg - rd_a_reg);

    // history update for the item retiring from stage 1
    always_comb begin
        we         = 1'b0;
        waddr      = wp_reg;
        wdata      = s1_seed_reg;
        wp_next    = wp_reg;
        count_next = count_reg;
        if (s1_go) begin
            case (s1_op_reg)
                OP_START: begin
                    we         = 1'b1;
                    waddr      = '0;
                    wp_next    = ptr_inc('0);
                    count_next = CNT_W'(1);
                end
                OP_APPEND: begin
                    we = 1'b1;
                end
                OP_GENERATE: begin
                    we    = lag_ok;
                    wdata = diff;
                end
                default: begin
                    we = 1'b0;
                end
            endcase
            if (we && (s1_op_reg != OP_START)) begin
                wp_next = ptr_inc(wp_reg);
                if (count_reg != CNT_W'(MAX_LAG)) begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    // taps of the next item are taken against the pointer after the retiring push
    assign raddr_a = tap_addr(wp_next, lag_a_reg);
    assign raddr_b = tap_addr(wp_next, lag_b_reg);

    // history RAM: one write port, two registered read ports with write bypass
    always_ff @(posedge aclk) begin
        if (we) begin
            hist_mem[waddr] <= wdata;
        end
        if (in_xfer) begin
            rd_a_reg <= (we && (waddr == raddr_a)) ? wdata : hist_mem[raddr_a];
            rd_b_reg <= (we && (waddr == raddr_b)) ? wdata : hist_mem[raddr_b];
        end
    end

    // control and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lag_a_reg     <= LAG_A_RESET;
            lag_b_reg     <= LAG_B_RESET;
            wp_reg        <= '0;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LAG_A: lag_a_reg <= cfg_data;
                    CFG_LAG_B: lag_b_reg <= cfg_data;
                    default:   ;
                endcase
            end
            wp_reg    <= wp_next;
            count_reg <= count_next;
            if (in_xfer) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go && (s1_op_reg == OP_GENERATE)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_op_reg   <= op_t'(s_tuser);
            s1_seed_reg <= s_tdata[WORD_W-1:0];
        end
        if (s1_go && (s1_op_reg == OP_GENERATE)) begin
            out_value_reg  <= lag_ok ? diff : '0;
            out_status_reg <= !lag_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_value_reg};
    assign m_tuser  = out_status_reg;

endmodule

// ===== hw/rtl/lfg_checker.sv =====
// Port-level checks for the lagged Fibonacci generator, bound to its top level.
module lfg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a short-history status always carries a zero value
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("status set with nonzero value");

    // generated words stay within 31 bits
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[31])
        else $error("padding bit set on result");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind lagged_fibonacci_abs_generator_top lfg_checker u_lfg_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for lagged_fibonacci_abs_generator_top.
`timescale 1ns / 1ps

module tb_top;
    import lfg_pkg::*;

    localparam int          PIPE_SLACK   = 4;          // pipeline latency plus margin
    localparam int          IDLE_PCT     = 34;
    localparam int          PHASE_ITEMS  = 160;
    localparam int          RUN_LIMIT_NS = 4_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(2);  // unmapped index

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              status;
    } draw_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;   // [30:0] seed_value, [31] zero
    logic [1:0]           s_tuser   = OP_NONE;  // [1:0] operation
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;          // [30:0] value, [31] zero
    logic [0:0]           m_tuser;          // [0] status
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LAG_W-1:0]     cfg_data  = '0;

    // Shadow copy of the generator state
    logic [WORD_W-1:0] hist_mem [0:MAX_LAG-1];
    int unsigned       hist_fill;
    int unsigned       hist_wptr;
    logic [LAG_W-1:0]  lag_a_q;
    logic [LAG_W-1:0]  lag_b_q;

    draw_t       expected_draws [$];
    draw_t       head_draw;
    int unsigned fault_count = 0;
    int unsigned burst_items = 0;
    bit          steady_mode = 1'b0;

    lagged_fibonacci_abs_generator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic void push_hist(logic [WORD_W-1:0] w);
        hist_mem[hist_wptr] = w;
        hist_wptr = (hist_wptr + 1) % MAX_LAG;
        if (hist_fill < MAX_LAG) hist_fill++;
    endfunction

    function automatic logic [WORD_W-1:0] tap_hist(int unsigned k);
        return hist_mem[(hist_wptr + MAX_LAG - k) % MAX_LAG];
    endfunction

    function automatic void predict_draw(op_t op, logic [WORD_W-1:0] seed);
        int unsigned       need;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        draw_t             d;
        case (op)
            OP_START: begin
                hist_fill = 0;
                hist_wptr = 0;
                push_hist(seed);
            end
            OP_APPEND: push_hist(seed);
            OP_GENERATE: begin
                need = 32'((lag_a_q > lag_b_q) ? lag_a_q : lag_b_q);
                if (lag_a_q == '0 || lag_b_q == '0 || hist_fill < need) begin
                    // short history or bad lag: flagged, history untouched
                    d.value  = '0;
                    d.status = 1'b1;
                end else begin
                    x = tap_hist(32'(lag_a_q));
                    y = tap_hist(32'(lag_b_q));
                    d.value  = (x > y) ? x - y : y - x;
                    d.status = 1'b0;
                    push_hist(d.value);
                end
                expected_draws.insert(expected_draws.size(), d);
            end
            default: ;  // unused code, ignored
        endcase
    endfunction

    // Track accepted input and config transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            hist_fill = 0;
            hist_wptr = 0;
            lag_a_q   = LAG_A_RESET;
            lag_b_q   = LAG_B_RESET;
        end else begin
            if (s_tvalid && s_tready) predict_draw(op_t'(s_tuser), s_tdata[WORD_W-1:0]);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LAG_A: lag_a_q = cfg_data;
                    CFG_LAG_B: lag_b_q = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ---------------- result checker ----------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_draws.size() == 0) begin
                $error("unexpected result transfer: value=%0h status=%0d",
                       m_tdata[WORD_W-1:0], m_tuser[0]);
                fault_count++;
            end else begin
                head_draw = expected_draws.pop_front();
                if (m_tdata[WORD_W-1:0] !== head_draw.value) begin
                    $error("value: expected %0h, actual %0h",
                           head_draw.value, m_tdata[WORD_W-1:0]);
                    fault_count++;
                end
                if (m_tuser[0] !== head_draw.status) begin
                    $error("status: expected %0d, actual %0d", head_draw.status, m_tuser[0]);
                    fault_count++;
                end
            end
        end
    end

    // Receiver backpressure
    always @(negedge aclk) begin
        m_tready <= steady_mode ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // ---------------- stimulus helpers ----------------
    task automatic send_item(op_t op, logic [WORD_W-1:0] seed);
        @(negedge aclk);
        while (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, seed};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop sending and wait until every expected result has arrived
    task automatic await_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_draws.size() != 0) @(posedge aclk);
        repeat (PIPE_SLACK) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LAG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_lags(logic [LAG_W-1:0] la, logic [LAG_W-1:0] lb);
        await_drain();
        write_reg(CFG_LAG_A, la);
        write_reg(CFG_LAG_B, lb);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // Item of a seeded burst, occasionally preceded by a stray item
    task automatic send_in_burst(op_t op);
        if ($urandom_range(99) < 5) begin
            send_item(op_t'($urandom_range(3)), rand_word());
            burst_items++;
        end
        send_item(op, rand_word());
        burst_items++;
    endtask

    // start + enough appends + a run of generates; some bursts stop seeding early
    task automatic run_seeded_burst(int unsigned need);
        int unsigned n_app;
        int unsigned n_gen;
        if ($urandom_range(99) < 15)
            n_app = $urandom_range(need - 1, 0);
        else
            n_app = need - 1 + $urandom_range(4);
        n_gen = $urandom_range(90, 1);
        send_in_burst(OP_START);
        repeat (n_app) send_in_burst(OP_APPEND);
        repeat (n_gen) send_in_burst(OP_GENERATE);
    endtask

    // ---------------- tests ----------------
    task automatic test_short_history();
        send_item(OP_GENERATE, '1);    // empty history
        send_item(OP_START, '1);
        send_item(OP_GENERATE, '0);    // one word, far below lag
        send_item(OP_NONE, '1);        // ignored
        send_item(OP_APPEND, '0);
        send_item(OP_GENERATE, '1);
    endtask

    // Reset lags are 24/55: 54 words is short, 55 is enough
    task automatic test_reset_lags();
        send_item(OP_START, rand_word());
        repeat (53) send_item(OP_APPEND, rand_word());
        send_item(OP_GENERATE, rand_word());
        send_item(OP_APPEND, rand_word());
        repeat (4) send_item(OP_GENERATE, rand_word());
    endtask

    task automatic test_field_extremes();
        set_lags(LAG_W'(1), LAG_W'(2));
        send_item(OP_START, '1);
        send_item(OP_APPEND, '0);
        send_item(OP_GENERATE, '0);    // full-scale difference
        send_item(OP_GENERATE, '1);
        send_item(OP_GENERATE, '0);    // equal taps -> zero
        send_item(OP_APPEND, 31'h5555_5555);
        send_item(OP_APPEND, 31'h2AAA_AAAA);
        send_item(OP_GENERATE, '0);
        send_item(OP_START, '0);       // restart drops history
        send_item(OP_GENERATE, '1);    // short again
        send_item(OP_APPEND, '0);
        send_item(OP_GENERATE, '0);
    endtask

    task automatic test_lag_corners();
        set_lags(LAG_W'(0), LAG_W'(2));       // zero lag is invalid
        send_item(OP_GENERATE, '0);
        set_lags(LAG_W'(65), LAG_W'(1));      // above window depth
        send_item(OP_GENERATE, '0);
        set_lags('1, '0);
        send_item(OP_GENERATE, '0);
        set_lags(LAG_W'(2), LAG_W'(1));
        write_reg(CFG_SPARE, '1);             // unmapped index, no effect
        send_item(OP_GENERATE, '1);
    endtask

    task automatic test_random_phases();
        logic [LAG_W-1:0] la;
        logic [LAG_W-1:0] lb;
        int unsigned      need;
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0:       begin la = LAG_W'(1);  lb = LAG_W'(1);  end
                1:       begin la = LAG_W'(64); lb = LAG_W'(64); end
                2:       begin la = LAG_W'(1);  lb = LAG_W'(64); end
                3:       begin la = LAG_W'(64); lb = LAG_W'(1);  end
                4:       begin la = LAG_W'(3);  lb = LAG_W'(31); end
                5:       begin la = LAG_W'(17); lb = LAG_W'(5);  end
                8: begin
                    la = LAG_W'($urandom_range(127));
                    lb = LAG_W'($urandom_range(127));
                end
                default: begin
                    la = LAG_W'($urandom_range(64, 1));
                    lb = LAG_W'($urandom_range(64, 1));
                end
            endcase
            set_lags(la, lb);
            need = 32'((la > lb) ? la : lb);
            if (need > MAX_LAG) need = MAX_LAG;
            if (need == 0) need = 1;
            steady_mode = (ph == 2);   // one stretch with no idling on either side
            burst_items = 0;
            while (burst_items < PHASE_ITEMS) begin
                run_seeded_burst(need);
                // sender holds off mid-phase until the result stream runs dry
                if (ph == 4 && burst_items >= PHASE_ITEMS / 2 && burst_items < PHASE_ITEMS)
                    await_drain();
            end
            steady_mode = 1'b0;
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_short_history();
        test_reset_lags();
        test_field_extremes();
        test_lag_corners();
        test_random_phases();

        await_drain();
        repeat (PIPE_SLACK) @(posedge aclk);
        if (expected_draws.size() != 0) begin
            $error("%0d expected results never arrived", expected_draws.size());
            fault_count++;
        end
        if (fault_count == 0) begin
            $display("** lagged_fibonacci_abs_generator_top: PASSED **");
        end else begin
            $display("** lagged_fibonacci_abs_generator_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("** lagged_fibonacci_abs_generator_top: FAILED **");
        $finish;
    end

endmodule
